/* src/rgb_to_hsl_macros.svh */
// Assertion macros shared by the checker.
`ifndef RGB_TO_HSL_MACROS_SVH
`define RGB_TO_HSL_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RTH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication; pass 1'b0 as rst to keep it active through reset.
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rth_pkg.sv */
package rth_pkg;

   localparam int CHAN_W      = 8;
   localparam int HUE_W       = 9;
   localparam int SAT_W       = 7;
   localparam int LIGHT_W     = 7;
   localparam int SUM_W       = CHAN_W + 1;
   localparam int DIFF_W      = CHAN_W + 1;
   localparam int HUE_T_W     = CHAN_W + 3;
   localparam int HUE_NUM_W   = 17;
   localparam int SAT_NUM_W   = 15;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_PAD_W   = RSP_DATA_W - HUE_W - SAT_W - LIGHT_W;

   localparam int HUE_STEP    = 60;
   localparam int HUE_WRAP    = 360;
   localparam int SAT_SCALE   = 100;
   localparam int CHAN_FULL   = 255;
   localparam int SUM_FULL    = 510;

   // 50 * 0x8081; (x * 0x8081) >> 23 == x / 255 for any 16-bit x
   localparam int LIGHT_RECIP  = 1644850;
   localparam int LIGHT_SHIFT  = 23;
   localparam int LIGHT_PROD_W = SUM_W + 21;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0]        mx;
      logic [CHAN_W-1:0]        mn;
      sector_type               sector;
      logic signed [DIFF_W-1:0] diff;
   } front_type;

   typedef struct packed {
      logic [HUE_NUM_W-1:0] hue_rem;
      logic [CHAN_W-1:0]    hue_div;
      logic [HUE_W-1:0]     hue_q;
      logic [SAT_NUM_W-1:0] sat_rem;
      logic [SUM_W-1:0]     sat_div;
      logic [SAT_W-1:0]     sat_q;
      logic [LIGHT_W-1:0]   light;
      logic                 grey;
      logic                 neg;
   } div_type;

   typedef struct packed {
      logic [LIGHT_W-1:0] lightness;
      logic [SAT_W-1:0]   saturation;
      logic [HUE_W-1:0]   hue;
   } hsl_type;

endpackage

/* src/rgb_to_hsl.sv */
// RGB to HSL pixel converter.
// req channel: one beat per pixel, 8-bit red, green and blue in req_tdata.
// rsp channel: one beat per pixel, hue in degrees (0..359), saturation and
// lightness in whole percent (0..100), truncated; grey gives hue and
// saturation of 0.
// Throughput: one pixel per clock unless the receiver stalls. The pipe has 12
// register stages: 2 operand stages, 9 divider stages, 1 output stage.
// The divider retires one hue quotient bit per stage and, in the last SAT_W
// stages, one saturation bit in parallel, so hue width sets the depth.
// Each stage has its own valid bit and loads when empty or when the stage
// after it moves, so a stalled receiver holds rsp_tdata steady while bubbles
// ahead of it still close up and req_tready stays high until the pipe fills.
// Synchronous reset drops every valid bit; no beat is in flight afterward.
module rgb_to_hsl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rth_pkg::REQ_DATA_W-1:0]   req_tdata,   // red, green, blue
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rth_pkg::RSP_DATA_W-1:0]   rsp_tdata    // hue, saturation, lightness, pad
);

   localparam int NSTAGE = rth_pkg::HUE_W;

   rth_pkg::pixel_type pix;
   rth_pkg::hsl_type   hsl;
   logic               div_valid [NSTAGE+1];
   logic               div_ready [NSTAGE+1];
   rth_pkg::div_type   div_data  [NSTAGE+1];

   assign pix.red   = req_tdata[0 +: rth_pkg::CHAN_W];
   assign pix.green = req_tdata[rth_pkg::CHAN_W +: rth_pkg::CHAN_W];
   assign pix.blue  = req_tdata[2*rth_pkg::CHAN_W +: rth_pkg::CHAN_W];

   rth_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (pix),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   for (genvar k = 0; k < NSTAGE; k++) begin : g_div
      rth_div_stage #(
         .BIT (NSTAGE - 1 - k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   rth_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid[NSTAGE]),
      .in_ready  (div_ready[NSTAGE]),
      .in_data   (div_data[NSTAGE]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (hsl)
   );

   assign rsp_tdata = {rth_pkg::RSP_PAD_W'(0), hsl.lightness, hsl.saturation, hsl.hue};

endmodule

/* src/rth_prep.sv */
module rth_prep (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rth_pkg::pixel_type in_pix,
   output logic               out_valid,
   input  logic               out_ready,
   output rth_pkg::div_type   out_data
);

   logic                 s1_valid_ff;
   rth_pkg::front_type   s1_ff;
   rth_pkg::front_type   s1_in;
   logic                 s1_ready;
   logic                 s2_valid_ff;
   rth_pkg::div_type     s2_ff;
   rth_pkg::div_type     s2_in;
   logic                 s2_ready;

   logic [rth_pkg::CHAN_W-1:0]       d;
   logic [rth_pkg::SUM_W-1:0]        s;
   logic [rth_pkg::LIGHT_PROD_W-1:0] light_prod;
   logic [rth_pkg::CHAN_W-1:0]       mag;
   logic signed [rth_pkg::HUE_T_W:0] ts;
   logic [rth_pkg::HUE_T_W-1:0]      t;

   // stage 1: max, min, sector and signed channel difference
   always_comb begin
      s1_in.mx = in_pix.red;
      s1_in.mn = in_pix.red;
      if (in_pix.green > s1_in.mx) s1_in.mx = in_pix.green;
      if (in_pix.blue  > s1_in.mx) s1_in.mx = in_pix.blue;
      if (in_pix.green < s1_in.mn) s1_in.mn = in_pix.green;
      if (in_pix.blue  < s1_in.mn) s1_in.mn = in_pix.blue;
      priority if (in_pix.blue == s1_in.mx) begin
         s1_in.sector = rth_pkg::SECT_BLUE;
         s1_in.diff   = $signed({1'b0, in_pix.red}) - $signed({1'b0, in_pix.green});
      end else if (in_pix.green == s1_in.mx) begin
         s1_in.sector = rth_pkg::SECT_GREEN;
         s1_in.diff   = $signed({1'b0, in_pix.blue}) - $signed({1'b0, in_pix.red});
      end else begin
         s1_in.sector = rth_pkg::SECT_RED;
         s1_in.diff   = $signed({1'b0, in_pix.green}) - $signed({1'b0, in_pix.blue});
      end
   end

   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: lightness, divider operands
   always_comb begin
      d          = s1_ff.mx - s1_ff.mn;
      s          = rth_pkg::SUM_W'(s1_ff.mx) + rth_pkg::SUM_W'(s1_ff.mn);
      light_prod = rth_pkg::LIGHT_PROD_W'(s)
                 * rth_pkg::LIGHT_PROD_W'(rth_pkg::LIGHT_RECIP);
      mag        = s1_ff.diff[rth_pkg::DIFF_W-1] ?
                   rth_pkg::CHAN_W'(-s1_ff.diff) : rth_pkg::CHAN_W'(s1_ff.diff);
      ts         = '0;
      unique case (s1_ff.sector)
         rth_pkg::SECT_RED:   ts = $signed({4'b0, mag});
         rth_pkg::SECT_GREEN: ts = (rth_pkg::HUE_T_W+1)'(s1_ff.diff)
                                 + $signed({3'b0, d, 1'b0});
         rth_pkg::SECT_BLUE:  ts = (rth_pkg::HUE_T_W+1)'(s1_ff.diff)
                                 + $signed({2'b0, d, 2'b0});
         default:             ts = '0;
      endcase
      t = ts[rth_pkg::HUE_T_W-1:0];

      s2_in.hue_rem = rth_pkg::HUE_NUM_W'(t) * rth_pkg::HUE_NUM_W'(rth_pkg::HUE_STEP);
      s2_in.hue_div = d;
      s2_in.hue_q   = '0;
      s2_in.sat_rem = rth_pkg::SAT_NUM_W'(d) * rth_pkg::SAT_NUM_W'(rth_pkg::SAT_SCALE);
      s2_in.sat_div = (s < rth_pkg::SUM_W'(rth_pkg::CHAN_FULL)) ?
                      s : rth_pkg::SUM_W'(rth_pkg::SUM_FULL) - s;
      s2_in.sat_q   = '0;
      s2_in.light   = light_prod[rth_pkg::LIGHT_SHIFT +: rth_pkg::LIGHT_W];
      s2_in.grey    = (d == '0);
      s2_in.neg     = (s1_ff.sector == rth_pkg::SECT_RED)
                      && s1_ff.diff[rth_pkg::DIFF_W-1];
   end

   assign s2_ready = !s2_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

/* src/rth_div_stage.sv */
module rth_div_stage #(
   parameter int BIT = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rth_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rth_pkg::div_type out_data
);

   logic                           valid_ff;
   rth_pkg::div_type               data_ff;
   rth_pkg::div_type               data_in;
   logic [rth_pkg::HUE_NUM_W-1:0]  hue_sub;
   logic [rth_pkg::SAT_NUM_W-1:0]  sat_rem_in;
   logic [rth_pkg::SAT_W-1:0]      sat_q_in;

   // one restoring step per quotient bit
   assign hue_sub = rth_pkg::HUE_NUM_W'(in_data.hue_div) << BIT;

   always_comb begin
      data_in = in_data;
      if (in_data.hue_rem >= hue_sub) begin
         data_in.hue_rem    = in_data.hue_rem - hue_sub;
         data_in.hue_q[BIT] = 1'b1;
      end
      data_in.sat_rem = sat_rem_in;
      data_in.sat_q   = sat_q_in;
   end

   if (BIT < rth_pkg::SAT_W) begin : g_sat
      logic [rth_pkg::SAT_NUM_W-1:0] sat_sub;
      assign sat_sub = rth_pkg::SAT_NUM_W'(in_data.sat_div) << BIT;
      always_comb begin
         sat_rem_in = in_data.sat_rem;
         sat_q_in   = in_data.sat_q;
         if (in_data.sat_rem >= sat_sub) begin
            sat_rem_in    = in_data.sat_rem - sat_sub;
            sat_q_in[BIT] = 1'b1;
         end
      end
   end else begin : g_no_sat
      assign sat_rem_in = in_data.sat_rem;
      assign sat_q_in   = in_data.sat_q;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/rth_finish.sv */
module rth_finish (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rth_pkg::div_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rth_pkg::hsl_type out_data
);

   logic             valid_ff;
   rth_pkg::hsl_type data_ff;
   rth_pkg::hsl_type data_in;

   always_comb begin
      data_in.lightness = in_data.light;
      priority if (in_data.grey) begin
         data_in.hue        = '0;
         data_in.saturation = '0;
      end else begin
         data_in.saturation = in_data.sat_q;
         // negative red-sector hue wraps; a zero quotient stays zero
         if (in_data.neg && (in_data.hue_q != '0)) begin
            data_in.hue = rth_pkg::HUE_W'(rth_pkg::HUE_WRAP) - in_data.hue_q;
         end else begin
            data_in.hue = in_data.hue_q;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/rth_checker.sv */
`include "rgb_to_hsl_macros.svh"

module rth_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rth_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                           out_free;
   logic                           out_stall;
   logic [rth_pkg::RSP_DATA_W:0]   rsp_beat;
   logic                           fields_ok;

   assign out_free  = !rsp_tvalid || rsp_tready;
   assign out_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = {rsp_tvalid, rsp_tdata};
   assign fields_ok =
      (rsp_tdata[rth_pkg::HUE_W-1:0] < rth_pkg::HUE_W'(rth_pkg::HUE_WRAP))
      && (rsp_tdata[rth_pkg::HUE_W +: rth_pkg::SAT_W]
          <= rth_pkg::SAT_W'(rth_pkg::SAT_SCALE))
      && (rsp_tdata[rth_pkg::HUE_W+rth_pkg::SAT_W +: rth_pkg::LIGHT_W]
          <= rth_pkg::LIGHT_W'(rth_pkg::SAT_SCALE));

   `RTH_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "rsp_tvalid high after reset")

   `RTH_ASSERT_NOW(a_ready_follows, clock, reset, out_free, req_tready, "req_tready low")

   `RTH_ASSERT_NEXT(a_rsp_hold, clock, reset, out_stall, $stable(rsp_beat), "rsp beat changed")

   `RTH_ASSERT_NOW(a_rsp_range, clock, reset, rsp_tvalid, fields_ok, "rsp field out of range")

endmodule

bind rgb_to_hsl rth_checker u_rth_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
